// ===== src/ubxnp_pkg.sv =====
package ubxnp_pkg;

    localparam int MAX_PAYLOAD_DEF = 128;

    localparam logic [7:0] SYNC1_BYTE = 8'hB5;
    localparam logic [7:0] SYNC2_BYTE = 8'h62;
    localparam logic [7:0] NAV_CLASS = 8'h01;
    localparam logic [7:0] PVT_ID = 8'h07;
    localparam logic [15:0] PVT_MIN_LEN = 16'd78;
    localparam logic [15:0] LLH_MIN_LEN = 16'd80;
    localparam logic [7:0] MIN_FIX_TYPE = 8'd2;

    localparam logic [4:0] CODE_FIXTYPE = 5'd1;
    localparam logic [4:0] CODE_FIXOK = 5'd2;
    localparam logic [4:0] CODE_LAST = 5'd18;

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_CLASS = 4'd2,
        PH_ID = 4'd3,
        PH_LEN1 = 4'd4,
        PH_LEN2 = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA = 4'd7,
        PH_CKB = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_READ,
        E_LAST,
        E_OUT
    } emit_state_t;

    typedef enum logic [2:0] {
        K_UNSIGNED,
        K_SIGNED,
        K_BIT0,
        K_TIMEVALID,
        K_POSVALID,
        K_VELVALID
    } field_kind_t;

    typedef struct packed {
        logic [6:0] offset;
        logic [1:0] last_idx;
        field_kind_t kind;
    } field_info_t;

    typedef struct packed {
        logic start;
        logic has_llh;
    } run_req_t;

    function automatic field_info_t field_info(input logic [4:0] code);
        field_info_t info;
        info = '{offset: 7'd0, last_idx: 2'd0, kind: K_UNSIGNED};
        unique case (code)
            5'd0:  info = '{offset: 7'd0,  last_idx: 2'd3, kind: K_UNSIGNED};
            5'd1:  info = '{offset: 7'd20, last_idx: 2'd0, kind: K_UNSIGNED};
            5'd2:  info = '{offset: 7'd21, last_idx: 2'd0, kind: K_BIT0};
            5'd3:  info = '{offset: 7'd11, last_idx: 2'd0, kind: K_TIMEVALID};
            5'd4:  info = '{offset: 7'd23, last_idx: 2'd0, kind: K_UNSIGNED};
            5'd5:  info = '{offset: 7'd24, last_idx: 2'd3, kind: K_SIGNED};
            5'd6:  info = '{offset: 7'd28, last_idx: 2'd3, kind: K_SIGNED};
            5'd7:  info = '{offset: 7'd36, last_idx: 2'd3, kind: K_SIGNED};
            5'd8:  info = '{offset: 7'd40, last_idx: 2'd3, kind: K_UNSIGNED};
            5'd9:  info = '{offset: 7'd44, last_idx: 2'd3, kind: K_UNSIGNED};
            5'd10: info = '{offset: 7'd48, last_idx: 2'd3, kind: K_SIGNED};
            5'd11: info = '{offset: 7'd52, last_idx: 2'd3, kind: K_SIGNED};
            5'd12: info = '{offset: 7'd56, last_idx: 2'd3, kind: K_SIGNED};
            5'd13: info = '{offset: 7'd60, last_idx: 2'd3, kind: K_SIGNED};
            5'd14: info = '{offset: 7'd64, last_idx: 2'd3, kind: K_SIGNED};
            5'd15: info = '{offset: 7'd68, last_idx: 2'd3, kind: K_UNSIGNED};
            5'd16: info = '{offset: 7'd76, last_idx: 2'd1, kind: K_UNSIGNED};
            5'd17: info = '{offset: 7'd78, last_idx: 2'd0, kind: K_POSVALID};
            5'd18: info = '{offset: 7'd21, last_idx: 2'd0, kind: K_VELVALID};
            default: info = '{offset: 7'd0, last_idx: 2'd0, kind: K_UNSIGNED};
        endcase
        return info;
    endfunction

endpackage

// ===== src/ubxnp_ram.sv =====
module ubxnp_ram #(
    parameter int DEPTH = 128,
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/ubxnp_rx.sv =====
module ubxnp_rx #(
    parameter int MAX_PAYLOAD = 128,
    parameter int AW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          rx_byte,
    input  logic                emit_busy,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output ubxnp_pkg::run_req_t run_req
);
    import ubxnp_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    phase_t phase_reg, phase_next;
    logic [7:0] class_reg, class_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_lo_reg, len_lo_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;

    logic accept;
    logic [7:0] add_a;
    logic [7:0] add_b;
    logic [15:0] full_len;
    logic [CW-1:0] count_inc;
    phase_t restart_phase;

    assign rx_stall = emit_busy && (phase_reg == PH_PAYLOAD);
    assign accept = rx_valid && !rx_stall;
    assign add_a = sum_a_reg + rx_byte;
    assign add_b = sum_b_reg + add_a;
    assign full_len = {rx_byte, len_lo_reg};
    assign count_inc = count_reg + CW'(1);
    assign restart_phase = (rx_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;

    assign wr_data = rx_byte;
    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            class_reg <= '0;
            id_reg <= '0;
            len_lo_reg <= '0;
            len_reg <= '0;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg <= id_next;
            len_lo_reg <= len_lo_next;
            len_reg <= len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next = id_reg;
        len_lo_next = len_lo_reg;
        len_next = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        wr_en = 1'b0;
        run_req = '{start: 1'b0, has_llh: 1'b0};
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == SYNC1_BYTE)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC2_BYTE)
                    begin
                        phase_next = PH_CLASS;
                        sum_a_next = '0;
                        sum_b_next = '0;
                    end
                    else if (rx_byte != SYNC1_BYTE)
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CLASS:
                begin
                    class_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_lo_next = rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LEN2;
                end
                PH_LEN2:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    count_next = '0;
                    if (full_len > 16'(MAX_PAYLOAD))
                    begin
                        phase_next = restart_phase;
                        len_next = '0;
                    end
                    else
                    begin
                        len_next = full_len[CW-1:0];
                        phase_next = (full_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en = (32'(count_reg) < MAX_PAYLOAD);
                    count_next = count_inc;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_CKA;
                    end
                end
                PH_CKA:
                begin
                    if (rx_byte == sum_a_reg)
                    begin
                        phase_next = PH_CKB;
                    end
                    else
                    begin
                        phase_next = restart_phase;
                        count_next = '0;
                        len_next = '0;
                    end
                end
                PH_CKB:
                begin
                    if ((rx_byte == sum_b_reg) && (class_reg == NAV_CLASS)
                        && (id_reg == PVT_ID) && (16'(len_reg) >= PVT_MIN_LEN))
                    begin
                        run_req.start = 1'b1;
                        run_req.has_llh = (16'(len_reg) >= LLH_MIN_LEN);
                    end
                    phase_next = restart_phase;
                    count_next = '0;
                    len_next = '0;
                end
                default:
                begin
                    phase_next = restart_phase;
                    count_next = '0;
                    len_next = '0;
                end
            endcase
        end
    end

endmodule

// ===== src/ubxnp_emit.sv =====
module ubxnp_emit #(
    parameter int AW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ubxnp_pkg::run_req_t run_req,
    output logic                emit_busy,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [7:0]          rd_data,
    output logic                field_valid,
    input  logic                field_stall,
    output logic [4:0]          field_code,
    output logic signed [32:0]  field_value,
    output logic                last_field
);
    import ubxnp_pkg::*;

    emit_state_t state_reg, state_next;
    logic [4:0] code_reg, code_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] pos_reg;
    logic rd_vld_reg;
    logic [31:0] acc_reg;
    logic has_llh_reg, has_llh_next;
    logic [7:0] fix_mode_reg;
    logic fix_ok_reg;
    logic out_valid_reg;
    logic [4:0] out_code_reg;
    logic signed [32:0] out_value_reg;
    logic out_last_reg;

    field_info_t info;
    logic out_free;
    logic load_out;
    logic clear_acc;
    logic vel_ok;
    logic signed [32:0] value;

    assign info = field_info(code_reg);
    assign out_free = !out_valid_reg || !field_stall;
    assign emit_busy = (state_reg != E_IDLE);
    assign rd_addr = AW'(info.offset) + AW'(idx_reg);
    assign vel_ok = fix_ok_reg && (fix_mode_reg >= MIN_FIX_TYPE);

    assign field_valid = out_valid_reg;
    assign field_code = out_code_reg;
    assign field_value = out_value_reg;
    assign last_field = out_last_reg;

    always_comb
    begin
        case (info.kind)
            K_UNSIGNED:  value = {1'b0, acc_reg};
            K_SIGNED:    value = {acc_reg[31], acc_reg};
            K_BIT0:      value = 33'(acc_reg[0]);
            K_TIMEVALID: value = 33'(acc_reg[1:0] == 2'b11);
            K_POSVALID:  value = 33'(vel_ok && !(has_llh_reg && acc_reg[0]));
            K_VELVALID:  value = 33'(vel_ok);
            default:     value = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        code_next = code_reg;
        idx_next = idx_reg;
        has_llh_next = has_llh_reg;
        rd_en = 1'b0;
        load_out = 1'b0;
        clear_acc = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (run_req.start)
                begin
                    code_next = '0;
                    idx_next = '0;
                    has_llh_next = run_req.has_llh;
                    clear_acc = 1'b1;
                    state_next = E_READ;
                end
            end
            E_READ:
            begin
                rd_en = 1'b1;
                if (idx_reg == info.last_idx)
                begin
                    state_next = E_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            E_LAST:
            begin
                state_next = E_OUT;
            end
            E_OUT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    clear_acc = 1'b1;
                    idx_next = '0;
                    if (code_reg == CODE_LAST)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        code_next = code_reg + 5'd1;
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            code_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            rd_vld_reg <= 1'b0;
            has_llh_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg <= code_next;
            idx_reg <= idx_next;
            pos_reg <= idx_reg;
            rd_vld_reg <= rd_en;
            has_llh_reg <= has_llh_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!field_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_reg[{pos_reg, 3'b000} +: 8] <= rd_data;
        end
        if (load_out)
        begin
            out_code_reg <= code_reg;
            out_value_reg <= value;
            out_last_reg <= (code_reg == CODE_LAST);
            if (code_reg == CODE_FIXTYPE)
            begin
                fix_mode_reg <= acc_reg[7:0];
            end
            if (code_reg == CODE_FIXOK)
            begin
                fix_ok_reg <= acc_reg[0];
            end
        end
    end

endmodule

// ===== src/ubx_frame_navpvt_extractor.sv =====
// Receives one serial byte per transfer, frames binary navigation messages
// (sync 0xB5 0x62, class, id, little-endian length, payload, Fletcher-8
// checksum) and, after a good class 1 / id 7 frame of at least 78 payload
// bytes, sends a run of 19 navigation fields, the last one flagged by
// last_field. Header, checksum and sync bytes are taken one per cycle at all
// times, and payload bytes one per cycle when no run is being sent. The
// payload sits in a single-port-read memory with one byte read per cycle. Each
// field is read in E_READ, its last byte lands in E_LAST, and E_OUT loads it
// into the output register once that is free; payload bytes of the next frame
// are stalled until the run has been handed to the output register.
module ubx_frame_navpvt_extractor #(
    parameter int MAX_PAYLOAD = ubxnp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               field_valid,
    input  logic               field_stall,
    output logic [4:0]         field_code,
    output logic signed [32:0] field_value,
    output logic               last_field
);
    import ubxnp_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);

    logic emit_busy;
    run_req_t run_req;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0] rd_data;

    ubxnp_rx #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .AW(AW)
    ) u_rx (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .emit_busy(emit_busy),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .run_req(run_req)
    );

    ubxnp_ram #(
        .DEPTH(MAX_PAYLOAD),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    ubxnp_emit #(
        .AW(AW)
    ) u_emit (
        .clk(clk),
        .rst_n(rst_n),
        .run_req(run_req),
        .emit_busy(emit_busy),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .field_valid(field_valid),
        .field_stall(field_stall),
        .field_code(field_code),
        .field_value(field_value),
        .last_field(last_field)
    );

endmodule

// ===== test/ubx_frame_navpvt_extractor_checker.sv =====
`timescale 1ns / 100ps

module ubx_frame_navpvt_extractor_checker #(
    parameter int MAX_PAYLOAD = ubxnp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_stall,
    input  logic [7:0]         rx_byte,
    input  logic               field_valid,
    input  logic               field_stall,
    input  logic [4:0]         field_code,
    input  logic signed [32:0] field_value,
    input  logic               last_field,
    output int                 fail_count,
    output int                 pending
);

    import ubxnp_pkg::*;

    localparam int PAW = $clog2(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        F_TOW,
        F_FIXTYPE,
        F_FIXOK,
        F_TIMEVALID,
        F_SATS,
        F_LON,
        F_LAT,
        F_HEIGHT,
        F_HACC,
        F_VACC,
        F_VELN,
        F_VELE,
        F_VELD,
        F_GSPEED,
        F_HEADING,
        F_SACC,
        F_PDOP,
        F_POSVALID,
        F_VELVALID
    } nav_code_t;

    typedef struct packed {
        logic [4:0]  code;
        logic [32:0] value;
        logic        last;
    } nav_field_t;

    nav_field_t nav_fields_due[$];

    phase_t     rx_phase;
    logic [7:0] hdr_class;
    logic [7:0] hdr_id;
    logic [15:0] pl_len;
    logic [15:0] pl_cnt;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] pl_mem [MAX_PAYLOAD];
    int         mismatches = 0;

    function automatic logic [7:0] mem_byte(input int at);
        return pl_mem[PAW'(at)];
    endfunction

    function automatic logic [15:0] mem_u16(input int at);
        return {mem_byte(at + 1), mem_byte(at)};
    endfunction

    function automatic logic [31:0] mem_u32(input int at);
        return {mem_u16(at + 2), mem_u16(at)};
    endfunction

    function automatic logic [32:0] sext32(input logic [31:0] v);
        return {v[31], v};
    endfunction

    task automatic push_field(input nav_code_t code, input logic [32:0] value);
        nav_field_t item;
        item.code = code;
        item.value = value;
        item.last = (code == CODE_LAST);
        nav_fields_due.push_back(item);
    endtask

    task automatic add_sum(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endtask

    // A byte that ends or breaks a frame may itself open the next one.
    task automatic hunt_from(input logic [7:0] b);
        rx_phase = (b == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
        pl_cnt = '0;
        pl_len = '0;
    endtask

    task automatic queue_nav_run();
        logic [7:0]  fix_mode;
        logic        fix_ok;
        logic        bad_llh;
        logic        vel_ok;
        logic [15:0] flags3;
        fix_mode = mem_byte(20);
        fix_ok = ((mem_byte(21) & 8'h01) != 8'h00);
        bad_llh = 1'b0;
        if (pl_len >= LLH_MIN_LEN)
        begin
            flags3 = mem_u16(78);
            bad_llh = flags3[0];
        end
        vel_ok = fix_ok && (fix_mode >= MIN_FIX_TYPE);
        push_field(F_TOW, {1'b0, mem_u32(0)});
        push_field(F_FIXTYPE, {25'd0, fix_mode});
        push_field(F_FIXOK, {32'd0, fix_ok});
        push_field(F_TIMEVALID, {32'd0, (mem_byte(11) & 8'h03) == 8'h03});
        push_field(F_SATS, {25'd0, mem_byte(23)});
        push_field(F_LON, sext32(mem_u32(24)));
        push_field(F_LAT, sext32(mem_u32(28)));
        push_field(F_HEIGHT, sext32(mem_u32(36)));
        push_field(F_HACC, {1'b0, mem_u32(40)});
        push_field(F_VACC, {1'b0, mem_u32(44)});
        push_field(F_VELN, sext32(mem_u32(48)));
        push_field(F_VELE, sext32(mem_u32(52)));
        push_field(F_VELD, sext32(mem_u32(56)));
        push_field(F_GSPEED, sext32(mem_u32(60)));
        push_field(F_HEADING, sext32(mem_u32(64)));
        push_field(F_SACC, {1'b0, mem_u32(68)});
        push_field(F_PDOP, {17'd0, mem_u16(76)});
        push_field(F_POSVALID, {32'd0, vel_ok && !bad_llh});
        push_field(F_VELVALID, {32'd0, vel_ok});
    endtask

    task automatic take_byte(input logic [7:0] b);
        case (rx_phase)
            PH_SYNC1:
            begin
                if (b == SYNC1_BYTE)
                    rx_phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (b == SYNC2_BYTE)
                begin
                    rx_phase = PH_CLASS;
                    ck_a = '0;
                    ck_b = '0;
                end
                else if (b != SYNC1_BYTE)
                begin
                    rx_phase = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                hdr_class = b;
                add_sum(b);
                rx_phase = PH_ID;
            end
            PH_ID:
            begin
                hdr_id = b;
                add_sum(b);
                rx_phase = PH_LEN1;
            end
            PH_LEN1:
            begin
                pl_len = {8'h00, b};
                add_sum(b);
                rx_phase = PH_LEN2;
            end
            PH_LEN2:
            begin
                pl_len[15:8] = b;
                add_sum(b);
                pl_cnt = '0;
                if (pl_len > MAX_PAYLOAD)
                    hunt_from(b);
                else
                    rx_phase = (pl_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (pl_cnt < MAX_PAYLOAD)
                    pl_mem[pl_cnt[PAW-1:0]] = b;
                pl_cnt = pl_cnt + 16'd1;
                add_sum(b);
                if (pl_cnt >= pl_len)
                    rx_phase = PH_CKA;
            end
            PH_CKA:
            begin
                if (b == ck_a)
                    rx_phase = PH_CKB;
                else
                    hunt_from(b);
            end
            PH_CKB:
            begin
                if (b == ck_b && hdr_class == NAV_CLASS && hdr_id == PVT_ID
                    && pl_len >= PVT_MIN_LEN)
                    queue_nav_run();
                hunt_from(b);
            end
            default:
            begin
                hunt_from(b);
            end
        endcase
    endtask

    task automatic check_field();
        nav_field_t want;
        if (nav_fields_due.size() == 0)
        begin
            $display("%0t: unexpected field transfer, code %0d value %h last %0b",
                     $time, field_code, field_value, last_field);
            mismatches++;
        end
        else
        begin
            want = nav_fields_due.pop_front();
            if (field_code !== want.code)
            begin
                $display("%0t: field_code expected %0d actual %0d",
                         $time, want.code, field_code);
                mismatches++;
            end
            if (field_value !== want.value)
            begin
                $display("%0t: field_value (code %0d) expected %h actual %h",
                         $time, want.code, want.value, field_value);
                mismatches++;
            end
            if (last_field !== want.last)
            begin
                $display("%0t: last_field (code %0d) expected %0b actual %0b",
                         $time, want.code, want.last, last_field);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase = PH_SYNC1;
            hdr_class = '0;
            hdr_id = '0;
            pl_len = '0;
            pl_cnt = '0;
            ck_a = '0;
            ck_b = '0;
            nav_fields_due.delete();
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
                take_byte(rx_byte);
            if (field_valid && !field_stall)
                check_field();
            pending <= nav_fields_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== test/ubx_frame_navpvt_extractor_tb.sv =====
`timescale 1ns / 100ps

module ubx_frame_navpvt_extractor_tb;

    import ubxnp_pkg::*;

    localparam int MAX_LEN = MAX_PAYLOAD_DEF;
    localparam int MIN_LEN = int'(PVT_MIN_LEN);
    localparam int LLH_LEN = int'(LLH_MIN_LEN);
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 300;
    localparam int BYTE_TARGET = 320;
    localparam int RUN_TARGET = 3;

    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM,
        FILL_NAV
    } fill_t;

    typedef enum int {
        CK_GOOD,
        CK_BAD_A,
        CK_BAD_B
    } ck_fault_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               field_valid;
    logic               field_stall = 1'b0;
    logic [4:0]         field_code;
    logic signed [32:0] field_value;
    logic               last_field;

    int fail_count;
    int pending;
    int sent_bytes = 0;
    int runs_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    ubx_frame_navpvt_extractor u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_code  (field_code),
        .field_value (field_value),
        .last_field  (last_field)
    );

    ubx_frame_navpvt_extractor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_code  (field_code),
        .field_value (field_value),
        .last_field  (last_field),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] corrupt(input logic [7:0] good, input bit as_sync);
        if (as_sync && good != SYNC1_BYTE)
            return SYNC1_BYTE;
        return good ^ 8'($urandom_range(1, 255));
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            field_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                field_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                field_stall <= 1'b0;
            end
        end
    end

    // The run ends if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (field_valid && !field_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic hold_until_drained();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                              input fill_t fill, input ck_fault_t fault, input bit as_sync);
        logic [7:0]  body[$];
        logic [7:0]  pb;
        logic [7:0]  sa;
        logic [7:0]  sb;
        logic [15:0] len16;
        len16 = len[15:0];
        body.push_back(cls);
        body.push_back(id);
        body.push_back(len16[7:0]);
        body.push_back(len16[15:8]);
        if (len <= MAX_LEN)
        begin
            for (int i = 0; i < len; i++)
            begin
                case (fill)
                    FILL_ZERO: pb = 8'h00;
                    FILL_ONES: pb = 8'hFF;
                    FILL_NAV:  pb = (i == 20) ? 8'($urandom_range(0, 4))
                                              : 8'($urandom_range(0, 255));
                    default:   pb = 8'($urandom_range(0, 255));
                endcase
                body.push_back(pb);
            end
        end
        sa = '0;
        sb = '0;
        foreach (body[k])
        begin
            sa = sa + body[k];
            sb = sb + sa;
        end
        send_byte(SYNC1_BYTE);
        send_byte(SYNC2_BYTE);
        foreach (body[k])
            send_byte(body[k]);
        if (len > MAX_LEN)
            return;
        if (fault == CK_BAD_A)
            sa = corrupt(sa, as_sync);
        else if (fault == CK_BAD_B)
            sb = corrupt(sb, as_sync);
        send_byte(sa);
        send_byte(sb);
        if (fault == CK_GOOD && cls == NAV_CLASS && id == PVT_ID && len >= MIN_LEN)
            runs_sent++;
    endtask

    initial
    begin
        int r;
        int len;
        int cut;
        fill_t fill;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(SYNC1_BYTE);
        send_frame(NAV_CLASS, PVT_ID, MIN_LEN, FILL_NAV, CK_GOOD, 1'b0);
        send_frame(NAV_CLASS, PVT_ID, 0, FILL_ZERO, CK_GOOD, 1'b0);
        send_frame(NAV_CLASS, PVT_ID, 16'hB501, FILL_ZERO, CK_GOOD, 1'b0);
        send_frame(NAV_CLASS, PVT_ID, MAX_LEN + 1, FILL_ZERO, CK_GOOD, 1'b0);
        send_frame(8'h05, 8'h01, 2, FILL_RANDOM, CK_GOOD, 1'b0);
        send_frame(NAV_CLASS, PVT_ID, 4, FILL_RANDOM, CK_BAD_A, 1'b1);
        send_frame(NAV_CLASS, PVT_ID, 4, FILL_RANDOM, CK_BAD_B, 1'b1);
        send_byte(SYNC1_BYTE);
        send_byte(8'h00);
        send_frame(NAV_CLASS, PVT_ID, LLH_LEN, FILL_ONES, CK_GOOD, 1'b0);
        hold_until_drained();

        while (sent_bytes < BYTE_TARGET || runs_sent < RUN_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0)
                hold_until_drained();
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                case ($urandom_range(0, 3))
                    0: len = MIN_LEN;
                    1: len = MIN_LEN + 1;
                    2: len = LLH_LEN;
                    default: len = $urandom_range(MIN_LEN, MAX_LEN);
                endcase
                fill = ($urandom_range(0, 9) == 0) ? FILL_RANDOM : FILL_NAV;
                if ($urandom_range(0, 19) == 0)
                    fill = FILL_ONES;
                send_frame(NAV_CLASS, PVT_ID, len, fill, CK_GOOD, 1'b0);
            end
            else if (r < 55)
            begin
                send_frame(NAV_CLASS, PVT_ID, $urandom_range(MIN_LEN, MAX_LEN), FILL_NAV,
                           ($urandom_range(0, 1) == 0) ? CK_BAD_A : CK_BAD_B,
                           1'($urandom_range(0, 1)));
            end
            else if (r < 65)
            begin
                case ($urandom_range(0, 2))
                    0: send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 20), FILL_RANDOM, CK_GOOD, 1'b0);
                    1: send_frame(8'($urandom_range(2, 255)), PVT_ID,
                                  $urandom_range(MIN_LEN, MAX_LEN), FILL_NAV, CK_GOOD, 1'b0);
                    default: send_frame(NAV_CLASS, PVT_ID, $urandom_range(0, MIN_LEN - 1),
                                        FILL_RANDOM, CK_GOOD, 1'b0);
                endcase
            end
            else if (r < 72)
            begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           $urandom_range(MAX_LEN + 1, 65535), FILL_ZERO, CK_GOOD, 1'b0);
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC1_BYTE
                                                          : 8'($urandom_range(0, 255)));
            end
            else if (r < 88)
            begin
                // A frame broken off inside its payload; the bytes that follow are
                // taken as the rest of it.
                len = $urandom_range(1, 40);
                cut = $urandom_range(0, len - 1);
                send_byte(SYNC1_BYTE);
                send_byte(SYNC2_BYTE);
                send_byte(NAV_CLASS);
                send_byte(PVT_ID);
                send_byte(len[7:0]);
                send_byte(8'h00);
                repeat (cut)
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(SYNC1_BYTE);
                if ($urandom_range(0, 1) == 0)
                    send_byte(SYNC1_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        calm = 1'b0;
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
